@@ rtl/cxfd_pkg.sv @@
// Package with shared types, constants and the CRC byte update for the frame deframer.
package cxfd_pkg;

	localparam int BYTE_W    = 8;
	localparam int CRC_W     = 16;
	localparam int FPOS_W    = 5;
	localparam int CNT_W     = 32;
	localparam int VERDICT_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h55;
	localparam logic [CRC_W-1:0]  CRC_SEED_RST   = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY_RST   = 16'h1021;
	localparam logic [FPOS_W-1:0] FLAGS_POS_RST  = 5'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE = 2'd0,
		REG_CRC_SEED   = 2'd1,
		REG_CRC_POLY   = 2'd2,
		REG_FLAGS_POS  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_PAYLOAD = 3'd1,
		PH_CRCL    = 3'd2,
		PH_CRCH    = 3'd3,
		PH_XOR     = 3'd4
	} phase_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_GOOD    = 2'd0,
		VERDICT_CRC_ERR = 2'd1,
		VERDICT_XOR_ERR = 2'd2
	} verdict_t;

	// Non-reflected CRC-16 update for one byte, top bit first.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b, input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/cxfd_if.sv @@
// Valid/ready channel interfaces for received bytes and frame results.
interface cxfd_byte_if;
	logic                      valid;
	logic                      ready;
	logic [cxfd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cxfd_res_if;
	logic                         valid;
	logic                         ready;
	logic [cxfd_pkg::VERDICT_W-1:0] verdict;
	logic [cxfd_pkg::BYTE_W-1:0]    flags_byte;
	logic [cxfd_pkg::CNT_W-1:0]     good_frames;
	logic [cxfd_pkg::CNT_W-1:0]     crc_failures;
	logic [cxfd_pkg::CNT_W-1:0]     xor_failures;
	logic                         link_ok;

	modport source (output valid, output verdict, output flags_byte, output good_frames,
		output crc_failures, output xor_failures, output link_ok, input ready);
	modport sink (input valid, input verdict, input flags_byte, input good_frames,
		input crc_failures, input xor_failures, input link_ok, output ready);
endinterface

@@ rtl/crc16_xor_frame_deframer_unit.sv @@
// Top level of the CRC-16 and XOR checked frame deframer.
// Each received word is one byte, so the block sustains one word per clock while the input
// is not held off; the CRC-16 byte update runs combinationally between the state registers
// and the next edge. A frame is a start byte, PAYLOAD_BYTES payload bytes, the CRC low and
// high bytes and an XOR byte; the result word appears on the result channel in the cycle after
// the XOR byte is taken and sits in an output register, so the input keeps flowing while it
// waits. The input is held off only when the next word is an XOR byte while that register is
// still full and its result is not taken in the same cycle.
// Configuration writes are meant for idle periods; start_byte and crc_seed act at the next
// start byte, crc_poly and flags_position at the next byte.
module crc16_xor_frame_deframer_unit #(
	parameter int PAYLOAD_BYTES = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cxfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [cxfd_pkg::CFG_DATA_W-1:0] cfg_data,
	cxfd_byte_if.sink                     rx,
	cxfd_res_if.source                    res
);
	import cxfd_pkg::*;

	localparam int IDX_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int CMP_W = (IDX_W > FPOS_W) ? IDX_W : FPOS_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

	// Configuration registers.
	logic [BYTE_W-1:0] start_byte_q;
	logic [CRC_W-1:0]  crc_seed_q;
	logic [CRC_W-1:0]  crc_poly_q;
	logic [FPOS_W-1:0] flags_pos_q;

	// Frame state.
	phase_t            phase_q, phase_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [BYTE_W-1:0] crcl_q, crcl_d;
	logic [BYTE_W-1:0] crch_q, crch_d;
	logic [BYTE_W-1:0] flags_q, flags_d;
	logic [CNT_W-1:0]  good_cnt_q, good_cnt_d;
	logic [CNT_W-1:0]  crc_cnt_q, crc_cnt_d;
	logic [CNT_W-1:0]  xor_cnt_q, xor_cnt_d;
	logic              link_q, link_d;

	// Result register.
	logic              res_valid_q;
	verdict_t          verdict_q, verdict_d;
	logic [BYTE_W-1:0] flags_out_q, flags_out_d;
	logic [CNT_W-1:0]  good_out_q, crc_out_q, xor_out_q;
	logic              link_out_q;
	logic              emit;

	logic              accept;
	logic [CRC_W-1:0]  crc_upd;
	logic [CRC_W-1:0]  rx_crc;

	// Only an XOR byte produces a result, so only that word has to wait for the result register.
	assign rx.ready = !res_valid_q || res.ready || (phase_q != PH_XOR);
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			crc_seed_q   <= CRC_SEED_RST;
			crc_poly_q   <= CRC_POLY_RST;
			flags_pos_q  <= FLAGS_POS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_START_BYTE: start_byte_q <= cfg_data[BYTE_W-1:0];
				REG_CRC_SEED:   crc_seed_q   <= cfg_data[CRC_W-1:0];
				REG_CRC_POLY:   crc_poly_q   <= cfg_data[CRC_W-1:0];
				REG_FLAGS_POS:  flags_pos_q  <= cfg_data[FPOS_W-1:0];
				default: ;
			endcase
		end
	end

	// The CRC update starts from the seed on a start byte, otherwise from the running value.
	assign crc_upd = crc_byte((phase_q == PH_HUNT) ? crc_seed_q : crc_q, rx.rx_byte, crc_poly_q);
	assign rx_crc  = {crch_q, crcl_q};

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx.rx_byte == start_byte_q) begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (idx_q == LAST_IDX) begin
					phase_d = PH_CRCL;
				end
			end
			PH_CRCL: phase_d = PH_CRCH;
			PH_CRCH: phase_d = PH_XOR;
			PH_XOR:  phase_d = PH_HUNT;
			default: phase_d = PH_HUNT;
		endcase
	end

	// Datapath and result.
	always_comb begin
		idx_d       = idx_q;
		crc_d       = crc_q;
		xor_d       = xor_q;
		crcl_d      = crcl_q;
		crch_d      = crch_q;
		flags_d     = flags_q;
		good_cnt_d  = good_cnt_q;
		crc_cnt_d   = crc_cnt_q;
		xor_cnt_d   = xor_cnt_q;
		link_d      = link_q;
		verdict_d   = VERDICT_GOOD;
		flags_out_d = '0;
		emit        = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx.rx_byte == start_byte_q) begin
					crc_d   = crc_upd;
					xor_d   = rx.rx_byte;
					idx_d   = '0;
					flags_d = '0;
				end
			end
			PH_PAYLOAD: begin
				crc_d = crc_upd;
				xor_d = xor_q ^ rx.rx_byte;
				if (CMP_W'(idx_q) == CMP_W'(flags_pos_q)) begin
					flags_d = rx.rx_byte;
				end
				idx_d = idx_q + IDX_W'(1);
			end
			PH_CRCL: begin
				crcl_d = rx.rx_byte;
				xor_d  = xor_q ^ rx.rx_byte;
			end
			PH_CRCH: begin
				crch_d = rx.rx_byte;
				xor_d  = xor_q ^ rx.rx_byte;
			end
			PH_XOR: begin
				emit = 1'b1;
				// A CRC mismatch wins when both checks fail.
				if (rx_crc != crc_q) begin
					verdict_d = VERDICT_CRC_ERR;
					crc_cnt_d = crc_cnt_q + CNT_W'(1);
				end else if (xor_q != rx.rx_byte) begin
					verdict_d = VERDICT_XOR_ERR;
					xor_cnt_d = xor_cnt_q + CNT_W'(1);
				end else begin
					verdict_d   = VERDICT_GOOD;
					good_cnt_d  = good_cnt_q + CNT_W'(1);
					link_d      = 1'b1;
					flags_out_d = flags_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			idx_q      <= '0;
			crc_q      <= CRC_SEED_RST;
			xor_q      <= '0;
			crcl_q     <= '0;
			crch_q     <= '0;
			flags_q    <= '0;
			good_cnt_q <= '0;
			crc_cnt_q  <= '0;
			xor_cnt_q  <= '0;
			link_q     <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			idx_q      <= idx_d;
			crc_q      <= crc_d;
			xor_q      <= xor_d;
			crcl_q     <= crcl_d;
			crch_q     <= crch_d;
			flags_q    <= flags_d;
			good_cnt_q <= good_cnt_d;
			crc_cnt_q  <= crc_cnt_d;
			xor_cnt_q  <= xor_cnt_d;
			link_q     <= link_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			verdict_q   <= verdict_d;
			flags_out_q <= flags_out_d;
			good_out_q  <= good_cnt_d;
			crc_out_q   <= crc_cnt_d;
			xor_out_q   <= xor_cnt_d;
			link_out_q  <= link_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.verdict      = verdict_q;
	assign res.flags_byte   = flags_out_q;
	assign res.good_frames  = good_out_q;
	assign res.crc_failures = crc_out_q;
	assign res.xor_failures = xor_out_q;
	assign res.link_ok      = link_out_q;

`ifndef SYNTHESIS
	a_xor_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_XOR |=> res_valid_q && phase_q == PH_HUNT)
		else $error("XOR byte did not produce a result");

	a_hunt_stays: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_HUNT && rx.rx_byte != start_byte_q |=> phase_q == PH_HUNT)
		else $error("left hunting without a start byte");

	a_payload_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_PAYLOAD |=> phase_q == PH_PAYLOAD || phase_q == PH_CRCL)
		else $error("bad phase after a payload byte");

	a_good_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && verdict_q == VERDICT_GOOD |-> link_out_q)
		else $error("good frame reported without link ok");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> res_valid_q)
		else $error("input stalled with an empty result register");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the CRC-16 and XOR checked frame deframer.
`timescale 1ns / 1ps

module testbench;
	import cxfd_pkg::*;

	localparam int FRAME_PAYLOAD  = 28;
	localparam int FRAME_LEN      = FRAME_PAYLOAD + 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;

	typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_XOR, FRAME_BAD_BOTH} frame_kind_t;

	typedef struct {
		verdict_t         verdict;
		logic [BYTE_W-1:0] flags;
		logic [CNT_W-1:0]  good;
		logic [CNT_W-1:0]  crc_fail;
		logic [CNT_W-1:0]  xor_fail;
		logic              link;
	} frame_report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	cxfd_byte_if rx_ch();
	cxfd_res_if  res_ch();

	crc16_xor_frame_deframer_unit #(
		.PAYLOAD_BYTES(FRAME_PAYLOAD)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.rx(rx_ch),
		.res(res_ch)
	);

	// Register copies seen by both the frame builder and the deframer model.
	logic [BYTE_W-1:0] cfg_start;
	logic [CRC_W-1:0]  cfg_seed;
	logic [CRC_W-1:0]  cfg_poly;
	logic [FPOS_W-1:0] cfg_fpos;

	// Deframer model state.
	phase_t            rx_phase;
	logic [7:0]        pay_idx;
	logic [CRC_W-1:0]  run_crc;
	logic [BYTE_W-1:0] run_xor;
	logic [BYTE_W-1:0] crc_lo;
	logic [BYTE_W-1:0] crc_hi;
	logic [BYTE_W-1:0] flags_hold;
	logic [CNT_W-1:0]  n_good;
	logic [CNT_W-1:0]  n_crc;
	logic [CNT_W-1:0]  n_xor;
	logic              link_seen;

	logic [BYTE_W-1:0] pending_bytes[$];
	frame_report_t     awaited_reports[$];
	frame_report_t     want;

	int  failures = 0;
	int  bytes_queued = 0;
	int  frames_queued = 0;
	int  bytes_taken = 0;
	int  reports_checked = 0;
	int  reg_writes = 0;
	int  settings_used = 1;
	int  burst_left = 0;
	int  gap_left = 0;
	int  sink_ticks = 0;
	int  idle_cycles = 0;
	bit  byte_taken = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// CRC-16, no reflection: each data bit enters at the top of the register.
	function automatic logic [CRC_W-1:0] crc16_advance(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = crc;
		for (int k = BYTE_W - 1; k >= 0; k--) begin
			fb = c[CRC_W-1] ^ data[k];
			c = {c[CRC_W-2:0], 1'b0} ^ (fb ? cfg_poly : '0);
		end
		return c;
	endfunction

	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		frame_report_t rep;
		case (rx_phase)
			PH_HUNT: begin
				if (b == cfg_start) begin
					run_crc = crc16_advance(cfg_seed, b);
					run_xor = b;
					pay_idx = '0;
					flags_hold = '0;
					rx_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				run_crc = crc16_advance(run_crc, b);
				run_xor ^= b;
				if (pay_idx == {3'b000, cfg_fpos}) begin
					flags_hold = b;
				end
				pay_idx = pay_idx + 8'd1;
				if (pay_idx >= FRAME_PAYLOAD) begin
					rx_phase = PH_CRCL;
				end
			end
			PH_CRCL: begin
				crc_lo = b;
				run_xor ^= b;
				rx_phase = PH_CRCH;
			end
			PH_CRCH: begin
				crc_hi = b;
				run_xor ^= b;
				rx_phase = PH_XOR;
			end
			PH_XOR: begin
				rep.flags = '0;
				// The CRC is judged first, so a frame failing both counts as a CRC error.
				if ({crc_hi, crc_lo} != run_crc) begin
					rep.verdict = VERDICT_CRC_ERR;
					n_crc = n_crc + 1;
				end else if (run_xor != b) begin
					rep.verdict = VERDICT_XOR_ERR;
					n_xor = n_xor + 1;
				end else begin
					rep.verdict = VERDICT_GOOD;
					n_good = n_good + 1;
					link_seen = 1'b1;
					rep.flags = flags_hold;
				end
				rep.good = n_good;
				rep.crc_fail = n_crc;
				rep.xor_fail = n_xor;
				rep.link = link_seen;
				awaited_reports.push_back(rep);
				rx_phase = PH_HUNT;
			end
			default: begin
				rx_phase = PH_HUNT;
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [CNT_W-1:0] exp_v,
		input logic [CNT_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			failures++;
		end
	endtask

	// Model first, then the result check, so a same-edge result would still find its entry.
	always @(posedge clk) begin
		byte_taken = 1'b0;
		if (arst_n && rx_ch.valid && rx_ch.ready) begin
			byte_taken = 1'b1;
			bytes_taken++;
			deframe_byte(rx_ch.rx_byte);
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual verdict %0d flags %0h",
					$time, res_ch.verdict, res_ch.flags_byte);
				failures++;
			end else begin
				want = awaited_reports.pop_front();
				reports_checked++;
				compare_field("verdict", want.verdict, res_ch.verdict);
				compare_field("flags_byte", want.flags, res_ch.flags_byte);
				compare_field("good_frames", want.good, res_ch.good_frames);
				compare_field("crc_failures", want.crc_fail, res_ch.crc_failures);
				compare_field("xor_failures", want.xor_fail, res_ch.xor_failures);
				compare_field("link_ok", want.link, res_ch.link_ok);
			end
		end
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else if (!rx_ch.valid || byte_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				rx_ch.valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				rx_ch.valid <= 1'b1;
				rx_ch.rx_byte <= pending_bytes.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: the stall pattern is picked by bits 8:7 of a free-running tick counter.
	always @(negedge clk) begin
		sink_ticks++;
		case (sink_ticks[8:7])
			2'd0: res_ch.ready <= 1'b1;
			2'd1: res_ch.ready <= ($urandom_range(0, 3) != 0);
			2'd2: res_ch.ready <= (sink_ticks[2:0] == 3'd0);
			default: res_ch.ready <= $urandom_range(0, 1);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
			|| cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_noise(input int n);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < n; i++) begin
			do begin
				b = 8'($urandom);
			end while (b == cfg_start);
			push_byte(b);
		end
	endtask

	// A negative fill gives a random payload, otherwise every payload byte is the fill.
	task automatic queue_frame(input frame_kind_t kind, input int fill);
		logic [BYTE_W-1:0] body[$];
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] parity;
		body.push_back(cfg_start);
		for (int i = 0; i < FRAME_PAYLOAD; i++) begin
			body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
		end
		crc = cfg_seed;
		for (int i = 0; i < body.size(); i++) begin
			crc = crc16_advance(crc, body[i]);
		end
		if (kind == FRAME_BAD_CRC || kind == FRAME_BAD_BOTH) begin
			crc ^= 16'($urandom_range(1, 65535));
		end
		body.push_back(crc[7:0]);
		body.push_back(crc[15:8]);
		parity = '0;
		for (int i = 0; i < body.size(); i++) begin
			parity ^= body[i];
		end
		if (kind == FRAME_BAD_XOR || kind == FRAME_BAD_BOTH) begin
			parity ^= 8'($urandom_range(1, 255));
		end
		body.push_back(parity);
		for (int i = 0; i < body.size(); i++) begin
			push_byte(body[i]);
		end
		frames_queued++;
	endtask

	// A frame cut short; with resync, the filler afterwards completes it and leaves the block hunting.
	task automatic queue_partial(input int len, input bit resync);
		push_byte(cfg_start);
		for (int i = 1; i < len; i++) begin
			push_byte(8'($urandom));
		end
		frames_queued++;
		if (resync) begin
			queue_noise(FRAME_LEN);
		end
	endtask

	task automatic queue_random_traffic(input int byte_goal, input int frame_goal);
		int pick;
		while (bytes_queued < byte_goal || frames_queued < frame_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				queue_frame(FRAME_GOOD, -1);
			end else if (pick < 78) begin
				queue_frame(FRAME_BAD_CRC, -1);
			end else if (pick < 84) begin
				queue_frame(FRAME_BAD_XOR, -1);
			end else if (pick < 88) begin
				queue_frame(FRAME_BAD_BOTH, -1);
			end else if (pick < 94) begin
				queue_noise($urandom_range(1, 5));
			end else begin
				queue_partial($urandom_range(1, FRAME_LEN - 1), 1'b1);
			end
		end
	endtask

	// Waits until every queued word has gone in and every result has come out.
	task automatic drain();
		do begin
			@(negedge clk);
		end while (pending_bytes.size() > 0 || rx_ch.valid || awaited_reports.size() > 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_START_BYTE: cfg_start = value[BYTE_W-1:0];
			REG_CRC_SEED:   cfg_seed = value;
			REG_CRC_POLY:   cfg_poly = value;
			default:        cfg_fpos = value[FPOS_W-1:0];
		endcase
		reg_writes++;
	endtask

	task automatic apply_settings(input logic [BYTE_W-1:0] start, input logic [CRC_W-1:0] seed,
		input logic [CRC_W-1:0] poly, input logic [FPOS_W-1:0] fpos);
		write_reg(REG_START_BYTE, {8'h00, start});
		write_reg(REG_CRC_SEED, seed);
		write_reg(REG_CRC_POLY, poly);
		write_reg(REG_FLAGS_POS, {11'd0, fpos});
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		cfg_start = START_BYTE_RST;
		cfg_seed = CRC_SEED_RST;
		cfg_poly = CRC_POLY_RST;
		cfg_fpos = FLAGS_POS_RST;
		rx_phase = PH_HUNT;
		pay_idx = '0;
		run_crc = CRC_SEED_RST;
		run_xor = '0;
		crc_lo = '0;
		crc_hi = '0;
		flags_hold = '0;
		n_good = '0;
		n_crc = '0;
		n_xor = '0;
		link_seen = 1'b0;

		// Directed frames under the reset settings; the error frames come first so that
		// link_ok is seen low before the first good frame.
		push_byte(8'h00);
		push_byte(8'hFF);
		queue_frame(FRAME_BAD_CRC, -1);
		queue_frame(FRAME_BAD_XOR, -1);
		queue_frame(FRAME_BAD_BOTH, -1);
		queue_frame(FRAME_GOOD, 8'h00);
		queue_frame(FRAME_GOOD, 8'hFF);
		queue_frame(FRAME_GOOD, cfg_start);
		queue_frame(FRAME_GOOD, -1);
		// Leave a frame open so that the next settings land in the middle of it.
		queue_partial(10, 1'b0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		drain();

		apply_settings(8'h00, 16'h0000, 16'hFFFF, 5'd27);
		queue_noise(FRAME_LEN);
		queue_random_traffic(450, 0);
		drain();

		apply_settings(8'hFF, 16'hFFFF, 16'h0000, 5'd31);
		queue_random_traffic(650, 0);
		drain();

		apply_settings(8'($urandom), 16'($urandom), 16'($urandom), 5'd28);
		queue_random_traffic(750, 0);
		// Hold the sender until the block has delivered everything, then carry on.
		drain();
		queue_random_traffic(850, 0);
		drain();

		apply_settings(START_BYTE_RST, CRC_SEED_RST, CRC_POLY_RST, 5'($urandom_range(0, 27)));
		queue_random_traffic(1050, 0);
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes and %0d results: %0d good, %0d CRC errors, %0d XOR errors.",
			bytes_taken, reports_checked, n_good, n_crc, n_xor);
		$display("Register writes: %0d over %0d settings, with frames cut short and noise.",
			reg_writes, settings_used);
		if (failures == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
